// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, fixed-point constants and register codes for the
// quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QW   = 18;  // quaternion component, Q2.16
  localparam int VW   = 32;  // vector component, Q16.16
  localparam int FRAC = 16;  // fraction bits dropped by each rounding step
  localparam int TW   = 35;  // intermediate q*v component after rounding
  localparam int RW   = 39;  // final component after rounding, before clamp

  localparam logic signed [RW-1:0] OUT_MAX = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] OUT_MIN = RW'(-64'sd2147483648);

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_I = 2'd1,
    REG_QUAT_J = 2'd2,
    REG_QUAT_K = 2'd3
  } reg_idx_t;

  typedef logic signed [QW-1:0] quat_comp_t;

endpackage

// ===== design/qvr_dot.sv =====
// ----------------------------------------------------------------------------
// qvr_dot
// Two-stage signed dot product: registered products, then a signed sum
// rounded half up to drop FRAC fraction bits. Per-term negation by NEG.
// ----------------------------------------------------------------------------
module qvr_dot #(
  parameter int            N   = 4,
  parameter int            A_W = 35,
  parameter int            B_W = 18,
  parameter int            R_W = 39,
  parameter logic [N-1:0]  NEG = 4'b0000
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [N-1:0][A_W-1:0] a,
  input  logic [N-1:0][B_W-1:0] b,
  output logic [R_W-1:0]        res
);
  import qvr_pkg::*;

  localparam int P_W = A_W + B_W;
  localparam int S_W = P_W + $clog2(N) + 1;
  localparam logic signed [S_W-1:0] HALF = S_W'(1) << (FRAC - 1);

  logic signed [P_W-1:0] prod_r   [N];
  logic signed [P_W-1:0] prod_nxt [N];
  logic signed [S_W-1:0] sum;
  logic signed [S_W-1:0] rnd;
  logic signed [S_W-1:0] shf;
  logic [R_W-1:0]        res_r;
  logic [R_W-1:0]        res_nxt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      prod_nxt[i] = $signed(a[i]) * $signed(b[i]);
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < N; i++) begin
      if (NEG[i]) begin
        sum = sum - S_W'(prod_r[i]);
      end else begin
        sum = sum + S_W'(prod_r[i]);
      end
    end
    rnd     = sum + HALF;
    shf     = rnd >>> FRAC;
    res_nxt = shf[R_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== design/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector by the Q2.16 quaternion q: vector part of
// q * (0, v) * conj(q), rounded half up per product stage, saturated to 32b.
// ----------------------------------------------------------------------------
// Throughput: one vector per cycle; the five-stage pipeline (two multiply
//   stages, two sum stages, one clamp stage) stalls as a whole on out_tready.
// Reset: synchronous active-low rst_n clears all valid bits and loads
//   q = (1.0, 0, 0, 0).
module quaternion_vector_rotate (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [17:0]   cfg_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [95:0]   out_tdata,  // rot_x [31:0], rot_y [63:32], rot_z [95:64]
  output logic [0:0]    out_tuser   // saturated [0]
);
  import qvr_pkg::*;

  quat_comp_t quat_r [4];

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  logic [VW-1:0] vx, vy, vz;
  logic [QW-1:0] qw, qi, qj, qk;
  logic [TW-1:0] tw, tx, ty, tz;
  logic [RW-1:0] rx, ry, rz;

  logic [95:0]   out_data_r, out_data_nxt;
  logic          out_sat_r, out_sat_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign vx = in_tdata[31:0];
  assign vy = in_tdata[63:32];
  assign vz = in_tdata[95:64];

  assign qw = quat_r[REG_QUAT_W];
  assign qi = quat_r[REG_QUAT_I];
  assign qj = quat_r[REG_QUAT_J];
  assign qk = quat_r[REG_QUAT_K];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[REG_QUAT_W] <= QW'(65536);
      quat_r[REG_QUAT_I] <= '0;
      quat_r[REG_QUAT_J] <= '0;
      quat_r[REG_QUAT_K] <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_QUAT_W: quat_r[REG_QUAT_W] <= cfg_data;
        REG_QUAT_I: quat_r[REG_QUAT_I] <= cfg_data;
        REG_QUAT_J: quat_r[REG_QUAT_J] <= cfg_data;
        REG_QUAT_K: quat_r[REG_QUAT_K] <= cfg_data;
        default: ;
      endcase
    end
  end

  // t = q * (0, v)
  qvr_dot #(.N(3), .A_W(VW), .B_W(QW), .R_W(TW), .NEG(3'b111)) u_tw (
    .clk(clk), .en(en), .a({vz, vy, vx}), .b({qk, qj, qi}), .res(tw)
  );
  qvr_dot #(.N(3), .A_W(VW), .B_W(QW), .R_W(TW), .NEG(3'b100)) u_tx (
    .clk(clk), .en(en), .a({vy, vz, vx}), .b({qk, qj, qw}), .res(tx)
  );
  qvr_dot #(.N(3), .A_W(VW), .B_W(QW), .R_W(TW), .NEG(3'b010)) u_ty (
    .clk(clk), .en(en), .a({vx, vz, vy}), .b({qk, qi, qw}), .res(ty)
  );
  qvr_dot #(.N(3), .A_W(VW), .B_W(QW), .R_W(TW), .NEG(3'b100)) u_tz (
    .clk(clk), .en(en), .a({vx, vy, vz}), .b({qj, qi, qw}), .res(tz)
  );

  // r = t * conj(q), vector part
  qvr_dot #(.N(4), .A_W(TW), .B_W(QW), .R_W(RW), .NEG(4'b0101)) u_rx (
    .clk(clk), .en(en), .a({tz, ty, tx, tw}), .b({qj, qk, qw, qi}), .res(rx)
  );
  qvr_dot #(.N(4), .A_W(TW), .B_W(QW), .R_W(RW), .NEG(4'b1001)) u_ry (
    .clk(clk), .en(en), .a({tz, ty, tx, tw}), .b({qi, qw, qk, qj}), .res(ry)
  );
  qvr_dot #(.N(4), .A_W(TW), .B_W(QW), .R_W(RW), .NEG(4'b0011)) u_rz (
    .clk(clk), .en(en), .a({tz, ty, tx, tw}), .b({qw, qi, qj, qk}), .res(rz)
  );

  // saturate to the 32-bit output range
  always_comb begin
    logic signed [RW-1:0] c [3];
    logic [2:0]           hit;
    c[0] = $signed(rx);
    c[1] = $signed(ry);
    c[2] = $signed(rz);
    hit  = '0;
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (c[i] > OUT_MAX) begin
        hit[i] = 1'b1;
        out_data_nxt[i*32 +: 32] = OUT_MAX[31:0];
      end else if (c[i] < OUT_MIN) begin
        hit[i] = 1'b1;
        out_data_nxt[i*32 +: 32] = OUT_MIN[31:0];
      end else begin
        out_data_nxt[i*32 +: 32] = c[i][31:0];
      end
    end
    out_sat_nxt = |hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

endmodule

// ===== tb/quaternion_vector_rotate_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Drives vectors through the rotator under several quaternion settings and
// checks every result against a bit-accurate fixed-point predictor or a
// stored expected value. A short table of directed cases comes first, then
// random phases with random quaternions, random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int     LATENCY     = 5;
  localparam int     MAX_GAP     = 8;
  localparam int     RAND_ITEMS  = 700;
  localparam int     HOLD_AT     = 200;   // results seen before the long sink stall
  localparam int     HOLD_LEN    = 120;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     ONE         = 65536;
  localparam int     QMAX        = 131071;
  localparam int     QMIN        = -131072;

  typedef struct packed {
    logic signed [VW-1:0] z;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic          sat;
    logic [VW-1:0] z;
    logic [VW-1:0] y;
    logic [VW-1:0] x;
  } rot_t;

  typedef struct packed {
    quat_comp_t qw;
    quat_comp_t qi;
    quat_comp_t qj;
    quat_comp_t qk;
    vec_t       v;
    logic       known;
    rot_t       want;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [17:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // rot_x [31:0], rot_y [63:32], rot_z [95:64]
  logic [0:0]   out_tuser;  // saturated [0]

  quaternion_vector_rotate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // testbench copy of the quaternion registers
  quat_comp_t q_w, q_i, q_j, q_k;

  rot_t       rot_q [$];
  dir_row_t   dir_rows [$];
  int         errors;
  int         rx_count;
  bit         burst;
  rot_t       got, want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint half_up(longint a);
    return (a + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic [VW-1:0] clamp_out(longint a, inout logic sat);
    if (a > longint'(OUT_MAX)) begin
      sat = 1'b1;
      return OUT_MAX[VW-1:0];
    end else if (a < longint'(OUT_MIN)) begin
      sat = 1'b1;
      return OUT_MIN[VW-1:0];
    end
    return a[VW-1:0];
  endfunction

  function automatic rot_t rotate_vec(vec_t v);
    longint sw, si, sj, sk, vx, vy, vz, tw, tx, ty, tz;
    logic   sat;
    rot_t   r;
    sw = q_w;
    si = q_i;
    sj = q_j;
    sk = q_k;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    // q * (0, v)
    tw = half_up(-si * vx - sj * vy - sk * vz);
    tx = half_up(sw * vx + sj * vz - sk * vy);
    ty = half_up(sw * vy - si * vz + sk * vx);
    tz = half_up(sw * vz + si * vy - sj * vx);
    // times conj(q), vector part
    sat = 1'b0;
    r.x = clamp_out(half_up(-tw * si + tx * sw - ty * sk + tz * sj), sat);
    r.y = clamp_out(half_up(-tw * sj + tx * sk + ty * sw - tz * si), sat);
    r.z = clamp_out(half_up(-tw * sk - tx * sj + ty * si + tz * sw), sat);
    r.sat = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_vec(input vec_t v, input rot_t exp_rot);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    rot_q.push_back(exp_rot);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (rot_q.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input quat_comp_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_quat(input quat_comp_t w, input quat_comp_t i,
                          input quat_comp_t j, input quat_comp_t k);
    wait_drained();
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_I, i);
    write_reg(REG_QUAT_J, j);
    write_reg(REG_QUAT_K, k);
    cfg_we <= 1'b0;
    q_w = w;
    q_i = i;
    q_j = j;
    q_k = k;
    @(negedge clk);
  endtask

  function automatic void add_row(int w, int i, int j, int k,
                                  logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic known, logic [31:0] ex, logic [31:0] ey,
                                  logic [31:0] ez, logic es);
    dir_row_t r;
    r.qw    = QW'(w);
    r.qi    = QW'(i);
    r.qj    = QW'(j);
    r.qk    = QW'(k);
    r.v     = {z, y, x};
    r.known = known;
    r.want  = {es, ez, ey, ex};
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 2097152) - 1048576;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h1;
        endcase
      end
    endcase
  endfunction

  function automatic quat_comp_t rand_quat_comp(int kind);
    case (kind)
      0: return QW'($urandom);
      1: return QW'($urandom_range(0, 92682) - 46341);
      default: begin
        case ($urandom_range(0, 4))
          0: return QW'(QMAX);
          1: return QW'(QMIN);
          2: return '0;
          3: return QW'(ONE);
          default: return QW'(-ONE);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- directed table

  function automatic void build_table();
    // identity at reset: output equals input
    add_row(ONE, 0, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0, 0);
    add_row(ONE, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h1,
            1, 32'h7fffffff, 32'h80000000, 32'h1, 0);
    add_row(ONE, 0, 0, 0, 32'hffffffff, 32'h00010000, 32'h80000001,
            1, 32'hffffffff, 32'h00010000, 32'h80000001, 0);
    add_row(ONE, 0, 0, 0, 32'h12345678, 32'hfedcba98, 32'h7fff0000,
            1, 32'h12345678, 32'hfedcba98, 32'h7fff0000, 0);
    // zero quaternion kills everything
    add_row(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            1, 32'h0, 32'h0, 32'h0, 0);
    // w = -2.0 scales by 4: clamps at both ends
    add_row(QMIN, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h0,
            1, 32'h7fffffff, 32'h80000000, 32'h0, 1);
    add_row(QMIN, 0, 0, 0, 32'h1, 32'hffffffff, 32'h00010000,
            1, 32'h4, 32'hfffffffc, 32'h00040000, 0);
    add_row(QMAX, 0, 0, 0, 32'h7fffffff, 32'h00001234, 32'hc0000000, 0, 0, 0, 0, 0);
    // half-way rounding with w = 0.5
    add_row(32768, 0, 0, 0, 32'h1, 32'hffffffff, 32'h3, 0, 0, 0, 0, 0);
    add_row(32768, 0, 0, 0, 32'h8001, 32'hffff7fff, 32'h00018000, 0, 0, 0, 0, 0);
    // 90 degrees about z, then half-turns about each axis
    add_row(46341, 0, 0, 46341, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0, 0);
    add_row(0, ONE, 0, 0, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0, 0);
    add_row(0, 0, ONE, 0, 32'h00010000, 32'hfffe0000, 32'h00030000, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, ONE, 32'h80000000, 32'h7fffffff, 32'h00030000, 0, 0, 0, 0, 0);
    // non-unit extremes in every component, then one mixed-sign case
    add_row(QMAX, QMAX, QMAX, QMAX, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            0, 0, 0, 0, 0);
    add_row(QMIN, QMIN, QMIN, QMIN, 32'h80000000, 32'h80000000, 32'h80000000,
            0, 0, 0, 0, 0);
    add_row(QMIN, QMAX, QMIN, QMAX, 32'h80000000, 32'h7fffffff, 32'hffffffff,
            0, 0, 0, 0, 0);
    add_row(QMIN, QMAX, QMIN, QMAX, 32'h00000100, 32'hffffff00, 32'h00000001,
            0, 0, 0, 0, 0);
    add_row(-ONE, 3, -5, 7, 32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 0, 0, 0, 0, 0);
  endfunction

  // ---------------------------------------------------------------- sink side

  initial begin : result_sink
    int stall;
    bit eager;
    bit held;
    out_tready <= 1'b0;
    eager = 1'b0;
    held  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) eager = !eager;
      if (!held && rx_count >= HOLD_AT) begin
        // long hold-off: pipeline fills and in_tready must drop
        held  = 1'b1;
        stall = HOLD_LEN;
      end else begin
        stall = eager ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (rot_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer: x=%h y=%h z=%h sat=%b",
                 $time, got.x, got.y, got.z, got.sat);
      end else begin
        want = rot_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.sat !== want.sat) begin
          errors++;
          $display("%0t: MISMATCH exp x=%h y=%h z=%h sat=%b  got x=%h y=%h z=%h sat=%b",
                   $time, want.x, want.y, want.z, want.sat,
                   got.x, got.y, got.z, got.sat);
        end
      end
      rx_count++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    dir_row_t row;
    vec_t     v;
    rot_t     exp_rot;
    int       n_rand;
    int       phase_len;
    int       qkind;
    int       vkind;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_QUAT_W;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    errors    = 0;
    rx_count  = 0;
    burst     = 1'b0;
    q_w = QW'(ONE);
    q_i = '0;
    q_j = '0;
    q_k = '0;
    build_table();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[n]) begin
      row = dir_rows[n];
      if ({row.qw, row.qi, row.qj, row.qk} != {q_w, q_i, q_j, q_k})
        set_quat(row.qw, row.qi, row.qj, row.qk);
      exp_rot = row.known ? row.want : rotate_vec(row.v);
      send_vec(row.v, exp_rot);
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      qkind = $urandom_range(0, 3);
      if (qkind == 3)
        set_quat(QW'(ONE), '0, '0, '0);
      else
        set_quat(rand_quat_comp(qkind), rand_quat_comp(qkind),
                 rand_quat_comp(qkind), rand_quat_comp(qkind));
      burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 90);
      if (phase_len > RAND_ITEMS - n_rand) phase_len = RAND_ITEMS - n_rand;
      repeat (phase_len) begin
        vkind = $urandom_range(0, 19);
        vkind = (vkind < 12) ? 0 : (vkind < 17) ? 1 : 2;
        v.x = rand_comp(vkind);
        v.y = rand_comp(vkind);
        v.z = rand_comp(vkind);
        send_vec(v, rotate_vec(v));
        n_rand++;
        // occasionally let the pipeline run dry mid-phase
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (LATENCY * 4) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
